FILE: sv/nfha_pkg.sv
// shared types and constants of the next-fit heap allocator
package nfha_pkg;

   // width of unwrapped position and size sums
   localparam int SUM_W = 18;
   // header length in bytes
   localparam logic [SUM_W-1:0] HDR = SUM_W'(3);

   typedef enum logic [2:0] {
      KIND_ALLOC   = 3'd0,
      KIND_FREE    = 3'd1,
      KIND_DESTROY = 3'd2,
      KIND_SETMARK = 3'd3,
      KIND_REUSE   = 3'd4,
      KIND_FIND    = 3'd5
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_HMOD,
      ST_HR0,
      ST_HR1,
      ST_HR2,
      ST_HR3,
      ST_HW0,
      ST_HW1,
      ST_HW2,
      ST_OP_WR,
      ST_F_START,
      ST_F_LOOP,
      ST_F_CHK,
      ST_A_POS,
      ST_A_IN,
      ST_A_IN2,
      ST_A_DEC,
      ST_A_NXT,
      ST_A_MSTART,
      ST_A_MOD,
      ST_A_FIN,
      ST_DONE
   } state_type;

endpackage

FILE: sv/next_fit_heap_allocator_top.sv
// next-fit heap allocator: sequencer over the byte store and modulo unit
//
// Each item is worked on alone; the result register lets the next item be
// taken while a result still waits. A header is read over the single read
// port of the byte store in states HR0 to HR3, and written in HW0 to HW2.
// Header addresses and the new rover are reduced modulo the heap length by a
// shared unit that subtracts the heap length once per cycle: a header
// address needs at most one subtraction there, the new rover one for each
// heap length that the sum overruns. Free, destroy, set mark and reuse take
// the address reduction, a header read, one write and the hand-over to the
// result register. Find adds a header read and a check per header walked.
// Allocate reads and merges each free header at each candidate and reads the
// header of each candidate that is rejected, then writes the header, reduces
// the rover, writes a tail header when a tail is split off and finishes, so
// its time grows with fragmentation. After reset the store is cleared and
// loaded with one free block in a pass during which no item is taken.
module next_fit_heap_allocator_top
   import nfha_pkg::*;
#(
   parameter int HEAP_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [11:0] req_length,
   input  logic [6:0]  req_tag,
   input  logic [11:0] req_payload_offset,
   input  logic        req_scan_from_base,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_success,
   output logic [11:0] rsp_result_offset
);

   localparam int AW = $clog2(HEAP_BYTES);
   localparam logic [SUM_W-1:0] HB = SUM_W'(HEAP_BYTES);

   function automatic logic [AW-1:0] wrap1(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] y;
      y = (x >= HB) ? x - HB : x;
      return y[AW-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] ext(input logic [AW-1:0] x);
      return SUM_W'(x);
   endfunction

   state_type        state_ff, state_in;
   state_type        ret_ff, ret_in;
   kind_type         kind_ff, kind_in;
   logic [11:0]      len_ff, len_in;
   logic [6:0]       tag_ff, tag_in;
   logic             base_ff, base_in;
   logic [AW-1:0]    h_ff, h_in;
   logic [AW-1:0]    hr_a_ff, hr_a_in;
   logic [7:0]       b0_ff, b0_in;
   logic [15:0]      size_ff, size_in;
   logic [SUM_W-1:0] p_ff, p_in;
   logic [SUM_W-1:0] start_ff, start_in;
   logic [SUM_W-1:0] span_ff, span_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    hw_a_ff, hw_a_in;
   logic [7:0]       hw_b0_ff, hw_b0_in;
   logic [15:0]      hw_size_ff, hw_size_in;
   logic [AW-1:0]    rover_ff, rover_in;
   logic             ok_ff, ok_in;
   logic [AW-1:0]    res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_success_ff, rsp_success_in;
   logic [11:0]      rsp_offset_ff, rsp_offset_in;

   logic             st_busy, st_we;
   logic [AW-1:0]    st_waddr, st_raddr;
   logic [7:0]       st_wdata, st_rdata;
   logic             md_start, md_done;
   logic [SUM_W-1:0] md_value;
   logic [AW-1:0]    md_rem;

   logic             accept;
   logic [SUM_W-1:0] need, size_ext, spare, res_ext;
   logic [6:0]       mark_now;

   nfha_store #(.HEAP_BYTES(HEAP_BYTES), .AW(AW)) u_store (
      .clock (clock),
      .reset (reset),
      .busy  (st_busy),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   nfha_modu #(.HEAP_BYTES(HEAP_BYTES), .AW(AW)) u_modu (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .value (md_value),
      .done  (md_done),
      .rem   (md_rem)
   );

   assign accept   = req_valid && !req_stall;
   assign need     = SUM_W'(len_ff) + HDR;
   assign size_ext = SUM_W'(size_ff);
   assign spare    = span_ff - need;
   assign res_ext  = ext(res_ff);

   // sequencer: next state, store access and modulo requests
   always_comb begin
      state_in       = state_ff;
      ret_in         = ret_ff;
      kind_in        = kind_ff;
      len_in         = len_ff;
      tag_in         = tag_ff;
      base_in        = base_ff;
      h_in           = h_ff;
      hr_a_in        = hr_a_ff;
      b0_in          = b0_ff;
      size_in        = size_ff;
      p_in           = p_ff;
      start_in       = start_ff;
      span_in        = span_ff;
      pos_in         = pos_ff;
      hw_a_in        = hw_a_ff;
      hw_b0_in       = hw_b0_ff;
      hw_size_in     = hw_size_ff;
      rover_in       = rover_ff;
      ok_in          = ok_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_success_in = rsp_success_ff;
      rsp_offset_in  = rsp_offset_ff;
      st_we          = 1'b0;
      st_waddr       = hw_a_ff;
      st_wdata       = hw_b0_ff;
      st_raddr       = hr_a_ff;
      md_start       = 1'b0;
      md_value       = SUM_W'(req_payload_offset) + HB - HDR;
      mark_now       = b0_ff[6:0];
      req_stall      = (state_ff != ST_IDLE) || st_busy;

      case (state_ff)
         // take an item; for every kind but allocate and the unused codes, start the header address reduction
         ST_IDLE: begin
            if (accept) begin
               kind_in  = kind_type'(req_kind);
               len_in   = req_length;
               tag_in   = req_tag;
               base_in  = req_scan_from_base;
               ok_in    = 1'b0;
               res_in   = '0;
               start_in = '0;
               case (kind_type'(req_kind))
                  KIND_ALLOC: state_in = ST_A_POS;
                  KIND_FREE, KIND_DESTROY, KIND_SETMARK, KIND_REUSE, KIND_FIND: begin
                     md_start = 1'b1;
                     state_in = ST_HMOD;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_HMOD: begin
            if (md_done) begin
               h_in    = md_rem;
               hr_a_in = md_rem;
               state_in = ST_HR0;
               if (kind_ff == KIND_FIND) begin
                  if (base_ff) begin
                     p_in     = '0;
                     state_in = ST_F_LOOP;
                  end else begin
                     ret_in = ST_F_START;
                  end
               end else begin
                  ret_in = ST_OP_WR;
               end
            end
         end
         // header read: byte 0, size low, size high
         ST_HR0: begin
            st_raddr = hr_a_ff;
            state_in = ST_HR1;
         end
         ST_HR1: begin
            st_raddr = wrap1(ext(hr_a_ff) + SUM_W'(1));
            b0_in    = st_rdata;
            state_in = ST_HR2;
         end
         ST_HR2: begin
            st_raddr      = wrap1(ext(hr_a_ff) + SUM_W'(2));
            size_in[7:0]  = st_rdata;
            state_in      = ST_HR3;
         end
         ST_HR3: begin
            size_in[15:8] = st_rdata;
            state_in      = ret_ff;
         end
         // header write: byte 0, size low, size high
         ST_HW0: begin
            st_we    = 1'b1;
            st_waddr = hw_a_ff;
            st_wdata = hw_b0_ff;
            state_in = ST_HW1;
         end
         ST_HW1: begin
            st_we    = 1'b1;
            st_waddr = wrap1(ext(hw_a_ff) + SUM_W'(1));
            st_wdata = hw_size_ff[7:0];
            state_in = ST_HW2;
         end
         ST_HW2: begin
            st_we    = 1'b1;
            st_waddr = wrap1(ext(hw_a_ff) + SUM_W'(2));
            st_wdata = hw_size_ff[15:8];
            state_in = ret_ff;
         end
         // single-byte header updates for free, destroy, set mark and reuse
         ST_OP_WR: begin
            st_we    = 1'b1;
            st_waddr = h_ff;
            state_in = ST_DONE;
            case (kind_ff)
               KIND_FREE, KIND_DESTROY: begin
                  if (kind_ff == KIND_DESTROY) begin
                     mark_now = 7'd0;
                  end
                  st_wdata = {1'b0, mark_now};
                  if (mark_now == 7'd0 &&
                      ext(rover_ff) == ext(h_ff) + HDR + size_ext) begin
                     rover_in = h_ff;
                  end
               end
               KIND_SETMARK: st_wdata = {b0_ff[7], tag_ff};
               KIND_REUSE: begin
                  st_wdata = {1'b1, b0_ff[6:0]};
                  ok_in    = 1'b1;
                  res_in   = wrap1(ext(h_ff) + HDR);
               end
               default: st_we = 1'b0;
            endcase
         end
         // find: linear walk over headers
         ST_F_START: begin
            p_in     = ext(h_ff) + HDR + size_ext;
            state_in = ST_F_LOOP;
         end
         ST_F_LOOP: begin
            if (p_ff >= HB) begin
               state_in = ST_DONE;
            end else begin
               hr_a_in  = p_ff[AW-1:0];
               ret_in   = ST_F_CHK;
               state_in = ST_HR0;
            end
         end
         ST_F_CHK: begin
            if (b0_ff[6:0] == tag_ff) begin
               ok_in    = 1'b1;
               res_in   = wrap1(p_ff + HDR);
               state_in = ST_DONE;
            end else begin
               p_in     = p_ff + HDR + size_ext;
               state_in = ST_F_LOOP;
            end
         end
         // allocate: next candidate from the rover
         ST_A_POS: begin
            if (start_ff >= HB) begin
               state_in = ST_DONE;
            end else begin
               pos_in   = wrap1(ext(rover_ff) + start_ff);
               span_in  = '0;
               state_in = ST_A_IN;
            end
         end
         // merge free blocks up to the heap end
         ST_A_IN: begin
            if (span_ff < need && span_ff < HB - ext(pos_ff)) begin
               hr_a_in  = pos_ff + span_ff[AW-1:0];
               ret_in   = ST_A_IN2;
               state_in = ST_HR0;
            end else begin
               state_in = ST_A_DEC;
            end
         end
         ST_A_IN2: begin
            if (b0_ff[7]) begin
               state_in = ST_A_DEC;
            end else begin
               span_in  = span_ff + HDR + size_ext;
               state_in = ST_A_IN;
            end
         end
         ST_A_DEC: begin
            if (span_ff >= need) begin
               hw_a_in  = pos_ff;
               hw_b0_in = {1'b1, tag_ff};
               if (spare > HDR) begin
                  hw_size_in = 16'(len_ff);
               end else begin
                  hw_size_in = 16'(span_ff - HDR);
               end
               ret_in   = ST_A_MSTART;
               state_in = ST_HW0;
            end else begin
               hr_a_in  = pos_ff;
               ret_in   = ST_A_NXT;
               state_in = ST_HR0;
            end
         end
         ST_A_NXT: begin
            start_in = start_ff + HDR + size_ext;
            state_in = ST_A_POS;
         end
         ST_A_MSTART: begin
            md_start = 1'b1;
            md_value = ext(pos_ff) + HDR + SUM_W'(hw_size_ff);
            state_in = ST_A_MOD;
         end
         // new rover, then the split-off tail header
         ST_A_MOD: begin
            if (md_done) begin
               rover_in = md_rem;
               ret_in   = ST_A_FIN;
               if (spare > HDR) begin
                  hw_a_in    = md_rem;
                  hw_b0_in   = 8'd0;
                  hw_size_in = 16'(spare - HDR);
                  state_in   = ST_HW0;
               end else begin
                  state_in = ST_A_FIN;
               end
            end
         end
         ST_A_FIN: begin
            ok_in    = 1'b1;
            res_in   = wrap1(ext(pos_ff) + HDR);
            state_in = ST_DONE;
         end
         // hand the result to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = ok_ff;
               rsp_offset_in  = res_ext[11:0];
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rover_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rover_ff     <= rover_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff         <= ret_in;
      kind_ff        <= kind_in;
      len_ff         <= len_in;
      tag_ff         <= tag_in;
      base_ff        <= base_in;
      h_ff           <= h_in;
      hr_a_ff        <= hr_a_in;
      b0_ff          <= b0_in;
      size_ff        <= size_in;
      p_ff           <= p_in;
      start_ff       <= start_in;
      span_ff        <= span_in;
      pos_ff         <= pos_in;
      hw_a_ff        <= hw_a_in;
      hw_b0_ff       <= hw_b0_in;
      hw_size_ff     <= hw_size_in;
      ok_ff          <= ok_in;
      res_ff         <= res_in;
      rsp_success_ff <= rsp_success_in;
      rsp_offset_ff  <= rsp_offset_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_success       = rsp_success_ff;
   assign rsp_result_offset = rsp_offset_ff;

`ifndef SYNTHESIS
   // rover stays inside the heap
   a_rover_range: assert property (@(posedge clock) disable iff (reset)
      ext(rover_ff) < HB)
      else $error("rover outside heap");

   // no store write from the sequencer during the clearing pass
   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      !(st_busy && st_we))
      else $error("store written while clearing");

   // an accepted item always starts work
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("item accepted without leaving idle");

   // modulo results arrive only where the sequencer waits for them
   a_mod_done_state: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == ST_HMOD || state_ff == ST_A_MOD))
      else $error("modulo result not awaited");
`endif

endmodule

FILE: sv/nfha_store.sv
// heap byte store with a clearing pass after reset
module nfha_store
   import nfha_pkg::*;
#(
   parameter int HEAP_BYTES = 4096,
   parameter int AW = 12
) (
   input  logic          clock,
   input  logic          reset,
   output logic          busy,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   localparam logic [15:0]   INIT_SIZE = 16'(HEAP_BYTES - 3);
   localparam logic [AW-1:0] LAST = AW'(HEAP_BYTES - 1);
   localparam logic [AW-1:0] ADDR_LO = AW'(1);
   localparam logic [AW-1:0] ADDR_HI = AW'(2);

   logic [7:0]    mem [HEAP_BYTES];
   logic          busy_ff, busy_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [7:0]    rdata_ff;
   logic [7:0]    init_byte;
   logic [AW-1:0] wa;
   logic [7:0]    wd;
   logic          wen;

   // initial image: one free unmarked block over the whole heap
   always_comb begin
      if (clr_ff == ADDR_LO) begin
         init_byte = INIT_SIZE[7:0];
      end else if (clr_ff == ADDR_HI) begin
         init_byte = INIT_SIZE[15:8];
      end else begin
         init_byte = 8'd0;
      end
      wen = busy_ff | we;
      wa  = busy_ff ? clr_ff : waddr;
      wd  = busy_ff ? init_byte : wdata;
   end

   // sweep counter
   always_comb begin
      busy_in = busy_ff;
      clr_in  = clr_ff;
      if (busy_ff) begin
         clr_in = clr_ff + AW'(1);
         if (clr_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[raddr];
   end

   assign busy  = busy_ff;
   assign rdata = rdata_ff;

endmodule

FILE: sv/nfha_modu.sv
// iterative modulo unit, one compare and subtract of the heap length per cycle
module nfha_modu
   import nfha_pkg::*;
#(
   parameter int HEAP_BYTES = 4096,
   parameter int AW = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] value,
   output logic             done,
   output logic [AW-1:0]    rem
);

   localparam logic [SUM_W-1:0] MODV = SUM_W'(HEAP_BYTES);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SUM_W-1:0] val_ff, val_in;

   // subtract the heap length until the value fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      if (start) begin
         busy_in = 1'b1;
         val_in  = value;
      end else if (busy_ff) begin
         if (val_ff >= MODV) begin
            val_in = val_ff - MODV;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign done = done_ff;
   assign rem  = val_ff[AW-1:0];

endmodule

FILE: bench/next_fit_heap_allocator_top_tb.sv
// self-checking bench for the next-fit heap allocator with its own heap predictor
module next_fit_heap_allocator_top_tb;
   import nfha_pkg::*;

   localparam int HEAP = 4096;
   localparam int HDR_LEN = 3;
   localparam int STALL_LIMIT = 30000000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [11:0] length;
      logic [6:0]  tag;
      logic [11:0] payload_offset;
      logic        scan_from_base;
   } op_item_type;

   typedef struct packed {
      logic        success;
      logic [11:0] result_offset;
   } heap_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [11:0] req_length = '0;
   logic [6:0]  req_tag = '0;
   logic [11:0] req_payload_offset = '0;
   logic        req_scan_from_base = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_success;
   logic [11:0] rsp_result_offset;

   next_fit_heap_allocator_top u_top (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [7:0]  heap_image [HEAP];
   int unsigned rover_pos;
   op_item_type     pending_ops [$];
   heap_result_type expected_results [$];
   logic [11:0]  live_blocks [$];
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  mismatches = 0;
   int unsigned  results_seen = 0;
   int unsigned  allocs_ok = 0;
   int unsigned  finds_ok = 0;
   int unsigned  quiet_cycles = 0;
   bit           stim_done = 1'b0;

   function automatic int unsigned wrap_addr(int unsigned a);
      return a % HEAP;
   endfunction

   function automatic int unsigned block_size(int unsigned p);
      return heap_image[wrap_addr(p + 1)] | (int'(heap_image[wrap_addr(p + 2)]) << 8);
   endfunction

   function automatic void put_header(int unsigned p, bit alloc, int unsigned mark,
                                      int unsigned size);
      heap_image[wrap_addr(p)] = {alloc, mark[6:0]};
      heap_image[wrap_addr(p + 1)] = size[7:0];
      heap_image[wrap_addr(p + 2)] = size[15:8];
   endfunction

   function automatic void heap_init();
      foreach (heap_image[i]) heap_image[i] = 8'h00;
      put_header(0, 1'b0, 0, HEAP - HDR_LEN);
      rover_pos = 0;
   endfunction

   function automatic void release_block(int unsigned h);
      heap_image[h][7] = 1'b0;
      if (heap_image[h][6:0] == 0 && rover_pos == h + HDR_LEN + block_size(h))
         rover_pos = h;
   endfunction

   // next-fit search with merging and tail split
   function automatic bit next_fit(int unsigned len, int unsigned tag,
                                   output int unsigned res);
      int unsigned need, start, span, pos, lim, bsize;
      bit found;
      need = len + HDR_LEN;
      start = 0;
      span = 0;
      pos = 0;
      found = 1'b0;
      res = 0;
      while (start < HEAP) begin
         pos = wrap_addr(rover_pos + start);
         lim = HEAP - pos;
         span = 0;
         while (span < need && span < lim && !heap_image[wrap_addr(pos + span)][7])
            span += HDR_LEN + block_size(wrap_addr(pos + span));
         if (span >= need) begin
            found = 1'b1;
            break;
         end
         start += HDR_LEN + block_size(pos);
      end
      if (!found) return 1'b0;
      if (span - need > HDR_LEN) begin
         put_header(pos, 1'b1, tag, len);
         rover_pos = wrap_addr(pos + HDR_LEN + len);
         put_header(wrap_addr(pos + HDR_LEN + len), 1'b0, 0, (span - need - HDR_LEN) & 16'hFFFF);
      end else begin
         bsize = (span - HDR_LEN) & 16'hFFFF;
         put_header(pos, 1'b1, tag, bsize);
         rover_pos = wrap_addr(pos + HDR_LEN + bsize);
      end
      res = wrap_addr(pos + HDR_LEN);
      return 1'b1;
   endfunction

   function automatic heap_result_type predict_heap_op(op_item_type it);
      heap_result_type r;
      int unsigned h, p, res;
      r = '0;
      h = wrap_addr(it.payload_offset + HEAP - HDR_LEN);
      case (it.kind)
         KIND_ALLOC: begin
            if (next_fit(it.length, it.tag, res)) begin
               r.success = 1'b1;
               r.result_offset = res[11:0];
            end
         end
         KIND_FREE: release_block(h);
         KIND_DESTROY: begin
            heap_image[h][6:0] = '0;
            release_block(h);
         end
         KIND_SETMARK: heap_image[h][6:0] = it.tag;
         KIND_REUSE: begin
            heap_image[h][7] = 1'b1;
            r.success = 1'b1;
            res = wrap_addr(h + HDR_LEN);
            r.result_offset = res[11:0];
         end
         KIND_FIND: begin
            p = it.scan_from_base ? 0 : h + HDR_LEN + block_size(h);
            while (p < HEAP) begin
               if (heap_image[wrap_addr(p)][6:0] == it.tag) begin
                  r.success = 1'b1;
                  res = wrap_addr(p + HDR_LEN);
                  r.result_offset = res[11:0];
                  break;
               end
               p += HDR_LEN + block_size(p);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic op_item_type make_op(logic [2:0] kind, int unsigned len,
                                           int unsigned tag, int unsigned ofs,
                                           bit from_base);
      op_item_type it;
      it.kind = kind;
      it.length = len[11:0];
      it.tag = tag[6:0];
      it.payload_offset = ofs[11:0];
      it.scan_from_base = from_base;
      return it;
   endfunction

   // mostly well-formed operations on live blocks, some noise
   function automatic op_item_type random_op();
      int unsigned sel, ofs, idx;
      logic [2:0] k;
      sel = $urandom_range(99);
      ofs = $urandom_range(4095);
      if (live_blocks.size() > 0 && $urandom_range(9) < 8) begin
         idx = $urandom_range(live_blocks.size() - 1);
         ofs = live_blocks[idx];
      end
      if (sel < 35) k = KIND_ALLOC;
      else if (sel < 55) k = KIND_FREE;
      else if (sel < 63) k = KIND_DESTROY;
      else if (sel < 73) k = KIND_SETMARK;
      else if (sel < 80) k = KIND_REUSE;
      else if (sel < 96) k = KIND_FIND;
      else k = 3'($urandom_range(6, 7));
      return make_op(k, ($urandom_range(19) == 0) ? $urandom_range(4095) : $urandom_range(120),
                     ($urandom_range(2) == 0) ? 0 : $urandom_range(127), ofs,
                     $urandom_range(1));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            op_item_type it;
            it = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_kind <= it.kind;
            req_length <= it.length;
            req_tag <= it.tag;
            req_payload_offset <= it.payload_offset;
            req_scan_from_base <= it.scan_from_base;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // monitor: predict on request accept, check on result accept
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            heap_result_type e;
            e = predict_heap_op(make_op(req_kind, req_length, req_tag, req_payload_offset,
                                        req_scan_from_base));
            if (req_kind == KIND_ALLOC && e.success) begin
               allocs_ok++;
               live_blocks.push_back(e.result_offset);
               if (live_blocks.size() > 40) void'(live_blocks.pop_front());
            end
            if (req_kind == KIND_FIND && e.success) finds_ok++;
            expected_results.push_back(e);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result: success %0b offset %0d",
                                              rsp_success, rsp_result_offset);
            end else begin
               heap_result_type e;
               e = expected_results.pop_front();
               if (e.success !== rsp_success || e.result_offset !== rsp_result_offset) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected success %0b offset %0d, got %0b %0d",
                              results_seen, e.success, e.result_offset, rsp_success,
                              rsp_result_offset);
               end
            end
         end
      end
   end

   // watchdog on cycles with no accepted item or result
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (!stim_done || expected_results.size() > 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic queue_random(int unsigned n);
      repeat (n) pending_ops.push_back(random_op());
      wait (pending_ops.size() == 0);
   endtask

   initial begin
      heap_init();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every kind, unused kinds, wrap of header address
      pending_ops.push_back(make_op(KIND_FIND, 0, 0, 0, 1'b1));
      pending_ops.push_back(make_op(KIND_ALLOC, 4093, 127, 0, 1'b0));
      pending_ops.push_back(make_op(KIND_ALLOC, 0, 1, 0, 1'b0));
      pending_ops.push_back(make_op(KIND_FREE, 0, 0, 3, 1'b0));
      pending_ops.push_back(make_op(KIND_ALLOC, 10, 5, 0, 1'b0));
      pending_ops.push_back(make_op(KIND_ALLOC, 0, 6, 0, 1'b0));
      pending_ops.push_back(make_op(KIND_ALLOC, 4095, 7, 0, 1'b0));
      pending_ops.push_back(make_op(KIND_FIND, 0, 6, 0, 1'b1));
      pending_ops.push_back(make_op(KIND_FIND, 0, 6, 3, 1'b0));
      pending_ops.push_back(make_op(KIND_FIND, 0, 99, 0, 1'b1));
      pending_ops.push_back(make_op(KIND_SETMARK, 0, 127, 16, 1'b0));
      pending_ops.push_back(make_op(KIND_DESTROY, 0, 0, 3, 1'b0));
      pending_ops.push_back(make_op(KIND_REUSE, 0, 0, 3, 1'b0));
      pending_ops.push_back(make_op(KIND_FREE, 0, 0, 16, 1'b0));
      pending_ops.push_back(make_op(KIND_REUSE, 0, 0, 1, 1'b0));
      pending_ops.push_back(make_op(KIND_SETMARK, 0, 42, 2, 1'b0));
      pending_ops.push_back(make_op(KIND_FIND, 0, 42, 4095, 1'b0));
      pending_ops.push_back(make_op(3'd6, 4095, 127, 4095, 1'b1));
      pending_ops.push_back(make_op(3'd7, 0, 0, 0, 1'b0));
      pending_ops.push_back(make_op(KIND_ALLOC, 2047, 85, 0, 1'b1));
      pending_ops.push_back(make_op(KIND_ALLOC, 1365, 42, 0, 1'b0));
      wait (pending_ops.size() == 0);
      send_idle_pct = 30;
      recv_idle_pct = 78;
      queue_random(280);
      send_idle_pct = 78;
      recv_idle_pct = 30;
      queue_random(280);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(290);
      @(posedge clock);
      stim_done = 1'b1;
      wait (!req_valid && expected_results.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d results: %0d successful allocations, %0d finds matched",
               results_seen, allocs_ok, finds_ok);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
